>>> rtl/core/triangle_tangent_vector_assert.svh
// Assertion macros shared by the triangle tangent RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef TRIANGLE_TANGENT_VECTOR_ASSERT_SVH
`define TRIANGLE_TANGENT_VECTOR_ASSERT_SVH
// Same-cycle implication.
`define TTV_ASSERT_IMPLY(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("triangle tangent assertion failed");
// Next-cycle implication.
`define TTV_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("triangle tangent assertion failed");
`endif

>>> rtl/core/ttv_pkg.sv
// Package for the triangle tangent block: widths, job and result types, states.
// No dependencies.
package ttv_pkg;
  localparam int POS_W   = 24;
  localparam int UV_W    = 20;
  localparam int E_W     = POS_W + 1;
  localparam int D_W     = UV_W + 1;
  localparam int OP_W    = (E_W > D_W) ? E_W : D_W;
  localparam int PROD_W  = D_W + OP_W;
  localparam int VEC_W   = PROD_W + 1;
  localparam int MAG_W   = VEC_W;
  localparam int NRM_W   = 31;
  localparam int SQ_W    = 2 * NRM_W;
  localparam int SUM_W   = 64;
  localparam int LEN_W   = 32;
  localparam int FRAC    = 16;
  localparam int NUM_W   = NRM_W + FRAC + 1;
  localparam int Q_W     = FRAC + 1;
  localparam int T_W     = 18;
  localparam int STEP_W  = 5;
  localparam int ONE     = 65536;

  typedef struct packed {
    logic signed [E_W-1:0] e1x;
    logic signed [E_W-1:0] e1y;
    logic signed [E_W-1:0] e1z;
    logic signed [E_W-1:0] e2x;
    logic signed [E_W-1:0] e2y;
    logic signed [E_W-1:0] e2z;
    logic signed [D_W-1:0] du1;
    logic signed [D_W-1:0] dv1;
    logic signed [D_W-1:0] du2;
    logic signed [D_W-1:0] dv2;
  } job_t;

  typedef struct packed {
    logic                  valid;
    logic signed [T_W-1:0] tan_x;
    logic signed [T_W-1:0] tan_y;
    logic signed [T_W-1:0] tan_z;
    logic                  degen;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_MUL, BK_CHK, BK_NORM, BK_SQ, BK_SQRT, BK_DIVSET, BK_DIV
  } back_state_e;
endpackage

>>> rtl/core/ttv_front.sv
// Front end: counts corners, holds the first two vertices, forms edge and UV deltas.
// Depends on ttv_pkg.
module ttv_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic signed [ttv_pkg::POS_W-1:0]  pos_x_i,
  input  logic signed [ttv_pkg::POS_W-1:0]  pos_y_i,
  input  logic signed [ttv_pkg::POS_W-1:0]  pos_z_i,
  input  logic signed [ttv_pkg::UV_W-1:0]   tex_u_i,
  input  logic signed [ttv_pkg::UV_W-1:0]   tex_v_i,
  output logic                              push_o,
  output ttv_pkg::job_t                     job_o
);
  localparam int EW = ttv_pkg::E_W;
  localparam int DW = ttv_pkg::D_W;

  logic [1:0] corner_q, corner_d;
  logic signed [ttv_pkg::POS_W-1:0] pos_q [6];
  logic signed [ttv_pkg::UV_W-1:0]  tex_q [4];

  assign push_o = accept_i && (corner_q == 2'd2);

  always_comb begin
    corner_d = corner_q;
    if (accept_i) begin
      corner_d = (corner_q == 2'd2) ? 2'd0 : corner_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q <= 2'd0;
    end else begin
      corner_q <= corner_d;
    end
  end

  // Held vertices carry no reset; the corner count guarantees a write first.
  always_ff @(posedge clk_i) begin
    if (accept_i && (corner_q != 2'd2)) begin
      if (corner_q[0]) begin
        pos_q[3] <= pos_x_i; pos_q[4] <= pos_y_i; pos_q[5] <= pos_z_i;
        tex_q[2] <= tex_u_i; tex_q[3] <= tex_v_i;
      end else begin
        pos_q[0] <= pos_x_i; pos_q[1] <= pos_y_i; pos_q[2] <= pos_z_i;
        tex_q[0] <= tex_u_i; tex_q[1] <= tex_v_i;
      end
    end
  end

  always_comb begin
    job_o.e1x = EW'(pos_q[3]) - EW'(pos_q[0]);
    job_o.e1y = EW'(pos_q[4]) - EW'(pos_q[1]);
    job_o.e1z = EW'(pos_q[5]) - EW'(pos_q[2]);
    job_o.e2x = EW'(pos_x_i)  - EW'(pos_q[0]);
    job_o.e2y = EW'(pos_y_i)  - EW'(pos_q[1]);
    job_o.e2z = EW'(pos_z_i)  - EW'(pos_q[2]);
    job_o.du1 = DW'(tex_q[2]) - DW'(tex_q[0]);
    job_o.dv1 = DW'(tex_q[3]) - DW'(tex_q[1]);
    job_o.du2 = DW'(tex_u_i)  - DW'(tex_q[0]);
    job_o.dv2 = DW'(tex_v_i)  - DW'(tex_q[1]);
  end
endmodule

>>> rtl/core/ttv_queue.sv
// Two-entry job queue between the front end and the back end.
// Depends on ttv_pkg.
module ttv_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ttv_pkg::job_t      job_i,
  input  logic               pop_i,
  output ttv_pkg::job_t      job_o,
  output ttv_pkg::q_status_t status_o
);
  ttv_pkg::job_t mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  assign job_o          = mem_q[rd_q];
  assign status_o.full  = cnt_q[1];
  assign status_o.empty = (cnt_q == 2'd0);
endmodule

>>> rtl/core/ttv_back.sv
// Back end: products, degenerate check, normalization, square root and divides.
// Depends on ttv_pkg and triangle_tangent_vector_assert.svh.
`include "triangle_tangent_vector_assert.svh"
module ttv_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             avail_i,
  input  ttv_pkg::job_t    job_i,
  output logic             pop_o,
  output ttv_pkg::result_t result_o
);
  localparam int PW  = ttv_pkg::PROD_W;
  localparam int VW  = ttv_pkg::VEC_W;
  localparam int MW  = ttv_pkg::MAG_W;
  localparam int NW  = ttv_pkg::NRM_W;
  localparam int SW  = ttv_pkg::SUM_W;
  localparam int LW  = ttv_pkg::LEN_W;
  localparam int QW  = ttv_pkg::Q_W;
  localparam int UW  = ttv_pkg::NUM_W;
  localparam int TW  = ttv_pkg::T_W;
  localparam int OW  = ttv_pkg::OP_W;
  localparam int RW  = LW + 2;

  ttv_pkg::back_state_e state_q, state_d;
  logic [ttv_pkg::STEP_W-1:0] step_q, step_d;
  logic [1:0]                 comp_q, comp_d;
  logic                       valid_q, valid_d;

  ttv_pkg::job_t          job_q, job_d;
  logic signed [PW-1:0]   prod_q, prod_d, hold_q, hold_d;
  logic signed [VW-1:0]   vec_q [4];
  logic signed [VW-1:0]   vec_d [4];
  logic [MW-1:0]          mag_q [3];
  logic [MW-1:0]          mag_d [3];
  logic [ttv_pkg::SQ_W-1:0] sq_q, sq_d;
  logic [SW-1:0]          sum_q, sum_d, x_q, x_d;
  logic [LW-1:0]          rem_q, rem_d, root_q, root_d, dr_q, dr_d;
  logic [QW-1:0]          nlow_q, nlow_d, quot_q, quot_d;
  logic signed [TW-1:0]   tan_q [3];
  logic signed [TW-1:0]   tan_d [3];
  logic                   degen_q, degen_d;

  logic signed [ttv_pkg::D_W-1:0] mul_a;
  logic signed [OW-1:0]           mul_b;
  logic [MW-1:0]                  orv;
  logic [RW-1:0]                  sq_r, sq_t;
  logic [UW-1:0]                  num;
  logic [LW:0]                    div_r;
  logic [QW-1:0]                  q_fin;
  logic [NW-1:0]                  m_sel;
  logic [1:0]                     vidx;
  logic [1:0]                     sidx;
  logic                           tan_zero, tan_in_range;

  // Operand select for the shared multiplier.
  always_comb begin
    case (step_q[2:0])
      3'd0:    begin mul_a = job_q.dv2; mul_b = OW'(job_q.e1x); end
      3'd1:    begin mul_a = job_q.dv1; mul_b = OW'(job_q.e2x); end
      3'd2:    begin mul_a = job_q.dv2; mul_b = OW'(job_q.e1y); end
      3'd3:    begin mul_a = job_q.dv1; mul_b = OW'(job_q.e2y); end
      3'd4:    begin mul_a = job_q.dv2; mul_b = OW'(job_q.e1z); end
      3'd5:    begin mul_a = job_q.dv1; mul_b = OW'(job_q.e2z); end
      3'd6:    begin mul_a = job_q.du1; mul_b = OW'(job_q.dv2); end
      default: begin mul_a = job_q.du2; mul_b = OW'(job_q.dv1); end
    endcase
  end

  always_comb begin
    state_d = state_q; step_d = step_q; comp_d = comp_q; valid_d = 1'b0;
    job_d = job_q; prod_d = prod_q; hold_d = hold_q;
    for (int i = 0; i < 4; i++) vec_d[i] = vec_q[i];
    for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i];
    for (int i = 0; i < 3; i++) tan_d[i] = tan_q[i];
    sq_d = sq_q; sum_d = sum_q; x_d = x_q; rem_d = rem_q; root_d = root_q;
    dr_d = dr_q; nlow_d = nlow_q; quot_d = quot_q; degen_d = degen_q;
    pop_o = 1'b0;
    orv   = mag_q[0] | mag_q[1] | mag_q[2];
    sq_r  = {rem_q, x_q[SW-1:SW-2]};
    sq_t  = {root_q, 2'b01};
    m_sel = mag_q[comp_q][NW-1:0];
    num   = {1'b0, m_sel, ttv_pkg::FRAC'(0)} + UW'(root_q >> 1);
    div_r = {dr_q, nlow_q[QW-1]};
    q_fin = {quot_q[QW-2:0], 1'b0};
    vidx  = 2'(step_q - 1'b1 >> 1);
    // The last squaring step only adds up; its product is never used.
    sidx  = (step_q[1:0] == 2'd3) ? 2'd0 : step_q[1:0];

    case (state_q)
      ttv_pkg::BK_IDLE: begin
        if (avail_i) begin
          pop_o   = 1'b1;
          job_d   = job_i;
          step_d  = '0;
          state_d = ttv_pkg::BK_MUL;
        end
      end
      ttv_pkg::BK_MUL: begin
        prod_d = mul_a * mul_b;
        if (step_q != '0) begin
          if (!step_q[0]) begin
            vec_d[vidx] = VW'(hold_q) - VW'(prod_q);
          end else begin
            hold_d = prod_q;
          end
        end
        step_d = step_q + 1'b1;
        if (step_q == ttv_pkg::STEP_W'(8)) begin
          state_d = ttv_pkg::BK_CHK;
        end
      end
      ttv_pkg::BK_CHK: begin
        for (int i = 0; i < 3; i++) begin
          mag_d[i] = vec_q[i][VW-1] ? MW'($unsigned(-vec_q[i])) : MW'($unsigned(vec_q[i]));
        end
        if ((vec_q[3] == '0) ||
            ((vec_q[0] == '0) && (vec_q[1] == '0) && (vec_q[2] == '0))) begin
          for (int i = 0; i < 3; i++) tan_d[i] = '0;
          degen_d = 1'b1;
          valid_d = 1'b1;
          state_d = ttv_pkg::BK_IDLE;
        end else begin
          degen_d = 1'b0;
          state_d = ttv_pkg::BK_NORM;
        end
      end
      ttv_pkg::BK_NORM: begin
        // One bit of shift a cycle until the largest magnitude sits in bit 30.
        if (orv[MW-1:NW] != '0) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] >> 1;
        end else if (!orv[NW-1]) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] << 1;
        end else begin
          step_d  = '0;
          state_d = ttv_pkg::BK_SQ;
        end
      end
      ttv_pkg::BK_SQ: begin
        sq_d  = mag_q[sidx][NW-1:0] * mag_q[sidx][NW-1:0];
        sum_d = (step_q == '0) ? '0 : sum_q + SW'(sq_q);
        step_d = step_q + 1'b1;
        if (step_q == ttv_pkg::STEP_W'(3)) begin
          x_d     = sum_q + SW'(sq_q);
          rem_d   = '0;
          root_d  = '0;
          step_d  = '0;
          state_d = ttv_pkg::BK_SQRT;
        end
      end
      ttv_pkg::BK_SQRT: begin
        if (sq_r >= sq_t) begin
          rem_d  = LW'(sq_r - sq_t);
          root_d = {root_q[LW-2:0], 1'b1};
        end else begin
          rem_d  = LW'(sq_r);
          root_d = {root_q[LW-2:0], 1'b0};
        end
        x_d    = x_q << 2;
        step_d = step_q + 1'b1;
        if (step_q == ttv_pkg::STEP_W'(LW - 1)) begin
          comp_d  = 2'd0;
          state_d = ttv_pkg::BK_DIVSET;
        end
      end
      ttv_pkg::BK_DIVSET: begin
        dr_d    = LW'(num[UW-1:QW]);
        nlow_d  = num[QW-1:0];
        quot_d  = '0;
        step_d  = '0;
        state_d = ttv_pkg::BK_DIV;
      end
      default: begin
        if (div_r >= {1'b0, root_q}) begin
          dr_d     = LW'(div_r - {1'b0, root_q});
          q_fin[0] = 1'b1;
        end else begin
          dr_d = LW'(div_r);
        end
        quot_d = q_fin;
        nlow_d = nlow_q << 1;
        step_d = step_q + 1'b1;
        if (step_q == ttv_pkg::STEP_W'(QW - 1)) begin
          tan_d[comp_q] = (vec_q[comp_q][VW-1] ^ vec_q[3][VW-1]) ?
                          -TW'(q_fin) : TW'(q_fin);
          if (comp_q == 2'd2) begin
            valid_d = 1'b1;
            state_d = ttv_pkg::BK_IDLE;
          end else begin
            comp_d  = comp_q + 2'd1;
            state_d = ttv_pkg::BK_DIVSET;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ttv_pkg::BK_IDLE;
      step_q  <= '0;
      comp_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      comp_q  <= comp_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d; prod_q <= prod_d; hold_q <= hold_d;
    for (int i = 0; i < 4; i++) vec_q[i] <= vec_d[i];
    for (int i = 0; i < 3; i++) mag_q[i] <= mag_d[i];
    for (int i = 0; i < 3; i++) tan_q[i] <= tan_d[i];
    sq_q <= sq_d; sum_q <= sum_d; x_q <= x_d; rem_q <= rem_d; root_q <= root_d;
    dr_q <= dr_d; nlow_q <= nlow_d; quot_q <= quot_d; degen_q <= degen_d;
  end

  assign result_o.valid = valid_q;
  assign result_o.tan_x = tan_q[0];
  assign result_o.tan_y = tan_q[1];
  assign result_o.tan_z = tan_q[2];
  assign result_o.degen = degen_q;

  assign tan_zero     = (tan_q[0] == '0) && (tan_q[1] == '0) && (tan_q[2] == '0);
  assign tan_in_range = (tan_q[0] <= TW'(ttv_pkg::ONE)) && (tan_q[0] >= -TW'(ttv_pkg::ONE));

  `TTV_ASSERT_IMPLY(a_degen_zero, result_o.valid && result_o.degen, tan_zero)
  `TTV_ASSERT_NEXT(a_one_strobe, result_o.valid, !result_o.valid)
  `TTV_ASSERT_IMPLY(a_unit_bound, result_o.valid, tan_in_range)
endmodule

>>> rtl/core/triangle_tangent_vector.sv
// Per-triangle tangent: the result strobe follows the edge that takes a third vertex,
// after hand-off, products, check, alignment, squares, root and three divides, or
// sooner, right after the check, when the triangle is degenerate.
// The back end works on one triangle at a time;
// vertices enter one a cycle until the two-entry job queue is full (busy_o).
// Reset (rst_ni, async, active low) clears the corner count, queue and sequencer; the
// receiver cannot stall: each result is shown for one cycle on result_valid_o.
module triangle_tangent_vector (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [ttv_pkg::POS_W-1:0]  pos_x_i,
  input  logic signed [ttv_pkg::POS_W-1:0]  pos_y_i,
  input  logic signed [ttv_pkg::POS_W-1:0]  pos_z_i,
  input  logic signed [ttv_pkg::UV_W-1:0]   tex_u_i,
  input  logic signed [ttv_pkg::UV_W-1:0]   tex_v_i,
  output logic                              result_valid_o,
  output logic signed [ttv_pkg::T_W-1:0]    tangent_x_o,
  output logic signed [ttv_pkg::T_W-1:0]    tangent_y_o,
  output logic signed [ttv_pkg::T_W-1:0]    tangent_z_o,
  output logic                              degenerate_o
);
  logic               accept, push, pop;
  ttv_pkg::job_t      fjob, qjob;
  ttv_pkg::q_status_t qstat;
  ttv_pkg::result_t   res;

  // A vertex is taken whenever the queue has room, even for corners that
  // produce no job, so the corner count never runs ahead of the queue.
  assign busy_o = qstat.full;
  assign accept = start_i && !busy_o;

  ttv_front u_front (
    .clk_i, .rst_ni, .accept_i(accept),
    .pos_x_i, .pos_y_i, .pos_z_i, .tex_u_i, .tex_v_i,
    .push_o(push), .job_o(fjob)
  );

  ttv_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .job_i(fjob), .pop_i(pop),
    .job_o(qjob), .status_o(qstat)
  );

  // The back end pops one job at a time and strobes its result once.
  ttv_back u_back (
    .clk_i, .rst_ni, .avail_i(!qstat.empty), .job_i(qjob),
    .pop_o(pop), .result_o(res)
  );

  assign result_valid_o = res.valid;
  assign tangent_x_o    = res.tan_x;
  assign tangent_y_o    = res.tan_y;
  assign tangent_z_o    = res.tan_z;
  assign degenerate_o   = res.degen;
endmodule

>>> sim/tb_triangle_tangent_vector.sv
// Self-checking testbench for triangle_tangent_vector: streams vertices, predicts
// each per-triangle unit tangent and compares it with the block's result strobe.
// Depends on ttv_pkg and the triangle_tangent_vector RTL.
module tb_triangle_tangent_vector;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POS_W = ttv_pkg::POS_W;
  localparam int UV_W  = ttv_pkg::UV_W;
  localparam int T_W   = ttv_pkg::T_W;

  // One vertex as it is driven onto the ports.
  typedef struct {
    logic signed [POS_W-1:0] pos [3];
    logic signed [UV_W-1:0]  u;
    logic signed [UV_W-1:0]  v;
  } vertex_t;

  // One expected tangent result.
  typedef struct {
    logic signed [T_W-1:0] tan [3];
    logic                  degen;
  } tangent_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic signed [POS_W-1:0] pos_x_i, pos_y_i, pos_z_i;
  logic signed [UV_W-1:0]  tex_u_i, tex_v_i;
  logic                    result_valid_o;
  logic signed [T_W-1:0]   tangent_x_o, tangent_y_o, tangent_z_o;
  logic                    degenerate_o;

  triangle_tangent_vector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .tex_u_i       (tex_u_i),
    .tex_v_i       (tex_v_i),
    .result_valid_o(result_valid_o),
    .tangent_x_o   (tangent_x_o),
    .tangent_y_o   (tangent_y_o),
    .tangent_z_o   (tangent_z_o),
    .degenerate_o  (degenerate_o)
  );

  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  vertex_t  vertex_queue [$];   // vertices waiting to be driven
  tangent_t tangent_queue [$];  // tangents still owed by the block
  int       error_count = 0;
  int       triangle_count = 0;
  int       degen_count = 0;
  int       accepted_count = 0;
  bit       vertex_taken = 0;   // set at the rising edge that accepts an item
  bit       burst_mode = 0;     // when set, no new random gaps are drawn
  int       gap_left = 0;

  // Predictor state: the first two corners of the triangle being built.
  logic signed [POS_W-1:0] corner_pos [2][3];
  logic signed [UV_W-1:0]  corner_u [2];
  logic signed [UV_W-1:0]  corner_v [2];
  int                      corner_idx = 0;

  // Appends a vertex to the stimulus list.
  task automatic add_vertex(vertex_t vx);
    vertex_queue.insert(vertex_queue.size(), vx);
  endtask

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic int bit_length(longint unsigned x);
    int n;
    n = 0;
    while (x != 0) begin
      n++;
      x >>= 1;
    end
    return n;
  endfunction

  // Computes the tangent of the triangle closed by vertex c. Products stay well
  // inside 64 bits at these widths, so plain signed arithmetic is exact.
  function automatic tangent_t triangle_tangent(vertex_t c);
    tangent_t        res;
    longint          e1, e2, du1, dv1, du2, dv2, det;
    longint          vec [3];
    longint unsigned mag [3];
    longint unsigned norm [3];
    longint unsigned sum, len, q, sq;
    int              maxlen;
    du1 = longint'(corner_u[1]) - longint'(corner_u[0]);
    dv1 = longint'(corner_v[1]) - longint'(corner_v[0]);
    du2 = longint'(c.u) - longint'(corner_u[0]);
    dv2 = longint'(c.v) - longint'(corner_v[0]);
    det = du1 * dv2 - du2 * dv1;
    maxlen = 0;
    for (int k = 0; k < 3; k++) begin
      e1 = longint'(corner_pos[1][k]) - longint'(corner_pos[0][k]);
      e2 = longint'(c.pos[k]) - longint'(corner_pos[0][k]);
      vec[k] = dv2 * e1 - dv1 * e2;
      mag[k] = (vec[k] < 0) ? longint'(-vec[k]) : longint'(vec[k]);
      if (bit_length(mag[k]) > maxlen) maxlen = bit_length(mag[k]);
    end
    if (det == 0 || maxlen == 0) begin
      foreach (res.tan[k]) res.tan[k] = '0;
      res.degen = 1'b1;
      return res;
    end
    // Scale all three together so the largest lands in [2^30, 2^31).
    for (int k = 0; k < 3; k++)
      norm[k] = (maxlen > 31) ? mag[k] >> (maxlen - 31) : mag[k] << (31 - maxlen);
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      sq = norm[k] * norm[k];
      sum += sq;
    end
    len = int_sqrt(sum);
    for (int k = 0; k < 3; k++) begin
      q = ((norm[k] << 16) + (len >> 1)) / len;
      if ((vec[k] < 0) != (det < 0)) q = -q;
      res.tan[k] = q[T_W-1:0];
    end
    res.degen = 1'b0;
    return res;
  endfunction

  // Driver: presents items at the falling edge and holds each until it is taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!(start_i && !vertex_taken)) begin
        vertex_taken = 0;
        if (gap_left > 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (vertex_queue.size() > 0) begin
          vertex_t vx;
          vx = vertex_queue.pop_front();
          pos_x_i <= vx.pos[0];
          pos_y_i <= vx.pos[1];
          pos_z_i <= vx.pos[2];
          tex_u_i <= vx.u;
          tex_v_i <= vx.v;
          start_i <= 1'b1;
          gap_left = burst_mode ? 0 : $urandom_range(0, 19);
          if ($urandom_range(0, 39) == 0) burst_mode = !burst_mode;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: records accepted vertices and checks each result strobe.
  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o && !vertex_taken) begin
      vertex_t vx;
      vertex_taken = 1;
      accepted_count++;
      vx.pos[0] = pos_x_i;
      vx.pos[1] = pos_y_i;
      vx.pos[2] = pos_z_i;
      vx.u = tex_u_i;
      vx.v = tex_v_i;
      if (corner_idx < 2) begin
        corner_pos[corner_idx] = vx.pos;
        corner_u[corner_idx] = vx.u;
        corner_v[corner_idx] = vx.v;
        corner_idx++;
      end else begin
        tangent_t t;
        corner_idx = 0;
        t = triangle_tangent(vx);
        if (t.degen) degen_count++;
        tangent_queue.insert(tangent_queue.size(), t);
      end
    end
    if (rst_ni && result_valid_o) begin
      if (tangent_queue.size() == 0) begin
        $error("result strobe with no triangle outstanding");
        error_count++;
      end else begin
        tangent_t t;
        t = tangent_queue.pop_front();
        triangle_count++;
        if (tangent_x_o !== t.tan[0]) begin
          $error("tangent_x expected %0d actual %0d", t.tan[0], tangent_x_o);
          error_count++;
        end
        if (tangent_y_o !== t.tan[1]) begin
          $error("tangent_y expected %0d actual %0d", t.tan[1], tangent_y_o);
          error_count++;
        end
        if (tangent_z_o !== t.tan[2]) begin
          $error("tangent_z expected %0d actual %0d", t.tan[2], tangent_z_o);
          error_count++;
        end
        if (degenerate_o !== t.degen) begin
          $error("degenerate expected %0d actual %0d", t.degen, degenerate_o);
          error_count++;
        end
      end
    end
  end

  function automatic vertex_t make_vertex(longint x, longint y, longint z,
                                          longint u, longint v);
    vertex_t vx;
    vx.pos[0] = x[POS_W-1:0];
    vx.pos[1] = y[POS_W-1:0];
    vx.pos[2] = z[POS_W-1:0];
    vx.u = u[UV_W-1:0];
    vx.v = v[UV_W-1:0];
    return vx;
  endfunction

  // Random vertex. Small magnitudes are mixed in so that both left and right
  // normalizing shifts are reached.
  function automatic vertex_t random_vertex(bit tiny);
    vertex_t vx;
    for (int k = 0; k < 3; k++)
      vx.pos[k] = tiny ? POS_W'($signed($urandom_range(0, 15)) - 8) : POS_W'($urandom);
    vx.u = tiny ? UV_W'($signed($urandom_range(0, 7)) - 4) : UV_W'($urandom);
    vx.v = tiny ? UV_W'($signed($urandom_range(0, 7)) - 4) : UV_W'($urandom);
    return vx;
  endfunction

  localparam longint PMAX = (64'sd1 <<< (POS_W - 1)) - 1;
  localparam longint PMIN = -(64'sd1 <<< (POS_W - 1));
  localparam longint UMAX = (64'sd1 <<< (UV_W - 1)) - 1;
  localparam longint UMIN = -(64'sd1 <<< (UV_W - 1));

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    pos_x_i = '0;
    pos_y_i = '0;
    pos_z_i = '0;
    tex_u_i = '0;
    tex_v_i = '0;

    // A plain unit triangle in the xy plane.
    add_vertex(make_vertex(0, 0, 0, 0, 0));
    add_vertex(make_vertex(65536, 0, 0, 65536, 0));
    add_vertex(make_vertex(0, 65536, 0, 0, 65536));
    // Equal texture coordinates: the UV determinant is zero.
    add_vertex(make_vertex(1, 2, 3, 100, 200));
    add_vertex(make_vertex(9, 8, 7, 100, 200));
    add_vertex(make_vertex(-5, 4, 0, 100, 200));
    // All corners at one point with a good UV map: the vector is zero.
    add_vertex(make_vertex(777, -777, 5, 0, 0));
    add_vertex(make_vertex(777, -777, 5, 65536, 0));
    add_vertex(make_vertex(777, -777, 5, 0, 65536));
    // Extreme positions and texture coordinates, largest products.
    add_vertex(make_vertex(PMIN, PMIN, PMAX, UMIN, UMAX));
    add_vertex(make_vertex(PMAX, PMAX, PMIN, UMAX, UMIN));
    add_vertex(make_vertex(PMIN, PMAX, PMIN, UMIN, UMIN));
    // The UV corners mirrored; the determinant keeps its sign.
    add_vertex(make_vertex(PMAX, PMIN, PMIN, UMAX, UMIN));
    add_vertex(make_vertex(PMIN, PMAX, PMAX, UMIN, UMAX));
    add_vertex(make_vertex(PMAX, PMAX, PMAX, UMAX, UMAX));
    // Tiny vector that needs a large left shift, with a negative determinant.
    add_vertex(make_vertex(0, 0, 0, 0, 0));
    add_vertex(make_vertex(1, 0, 0, 0, 1));
    add_vertex(make_vertex(0, 0, 1, 1, 0));
    // Tangent exactly along one negative axis.
    add_vertex(make_vertex(0, 0, 0, 0, 0));
    add_vertex(make_vertex(0, -65536, 0, 65536, 0));
    add_vertex(make_vertex(0, 0, 65536, 0, 65536));
    // All-zero corners.
    repeat (3) add_vertex(make_vertex(0, 0, 0, 0, 0));

    // Random triangles: mostly full range, some tiny, some with shared UVs.
    for (int n = 0; n < 192; n++) begin
      vertex_t a, b, c;
      bit tiny;
      tiny = ($urandom_range(0, 4) == 0);
      a = random_vertex(tiny);
      b = random_vertex(tiny);
      c = random_vertex(tiny);
      if ($urandom_range(0, 9) == 0) begin
        b.u = a.u;
        b.v = a.v;
      end
      if ($urandom_range(0, 14) == 0) c.pos = a.pos;
      add_vertex(a);
      add_vertex(b);
      add_vertex(c);
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (vertex_queue.size() == 0 && !start_i && tangent_queue.size() == 0);
    // The block should now be silent; give it a full triangle span to misbehave.
    repeat (300) @(posedge clk_i);
    $display("Covered %0d vertices and %0d triangles, %0d of them degenerate.",
             accepted_count, triangle_count, degen_count);
    if (error_count == 0) begin
      $display("triangle_tangent_vector verification clean");
    end else begin
      $display("triangle_tangent_vector verification failed");
    end
    $finish;
  end

  // Watchdog, far above the slowest correct run.
  initial begin
    #2000000;
    $display("Timed out with %0d tangents outstanding.", tangent_queue.size());
    $display("triangle_tangent_vector verification failed");
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl/core
rtl/core/ttv_pkg.sv
rtl/core/ttv_front.sv
rtl/core/ttv_queue.sv
rtl/core/ttv_back.sv
rtl/core/triangle_tangent_vector.sv
sim/tb_triangle_tangent_vector.sv
